// File: rtl/ffbta_pkg.sv
// ----------------------------------------------------------------------------
// ffbta_pkg
// Shared constants and types for the first-fit boundary-tag allocator.
// ----------------------------------------------------------------------------
package ffbta_pkg;

   localparam int ARENA_MAX_BYTES = 4096;
   localparam int HEADER_BYTES    = 8;
   localparam int POS_W           = $clog2(ARENA_MAX_BYTES) + 1;
   localparam int ADDR_W          = 12;
   localparam int TAG_W           = 8;

   localparam logic [TAG_W-1:0] FREE_TAG = 8'hFF;
   localparam logic [POS_W-1:0] HDR      = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] HDR2     = POS_W'(2 * HEADER_BYTES);
   localparam logic [POS_W-1:0] END_MAX  = POS_W'(ARENA_MAX_BYTES);

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_MOVED = 2'd1;
   localparam logic [1:0] ST_FAIL  = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0] len;
      logic [TAG_W-1:0] tag;
   } word_type;

endpackage

// File: rtl/first_fit_boundary_tag_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit
// Arena allocator: block headers kept in one synchronous memory, walked
// header by header for allocate, free, and resize.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    op, addr, size, block_type
//  rsp      out  rsp_valid/rsp_ready    status, result_addr, copy_from/bytes
//  csr      in   csr_wr_en              arena_bytes (13 bits)
//
//  Each header visited is read from memory, then evaluated; a moving resize
//  walks the chain up to three times. Reset and each arena write pass through
//  S_INIT, writing the root header, with req_ready low. A result waits in the
//  output register; the next beat is taken meanwhile but cannot finish until
//  that register drains.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [11:0] req_addr,
   input  logic [11:0] req_size,
   input  logic [7:0]  req_block_type,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_result_addr,
   output logic [11:0] rsp_copy_from,
   output logic [11:0] rsp_copy_bytes,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   localparam int PW = ffbta_pkg::POS_W;
   localparam int AW = ffbta_pkg::ADDR_W;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_AL_RD, S_AL_EV, S_AL_WR2, S_LC_RD, S_LC_EV,
      S_BK_EV, S_NX_EV, S_PV_EV, S_RZ_NX, S_RZ_WR2, S_RESP
   } state_type;

   ffbta_pkg::word_type mem [ffbta_pkg::ARENA_MAX_BYTES];
   ffbta_pkg::word_type rd_data_ff;
   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr, wr_addr;
   ffbta_pkg::word_type wr_data;

   state_type        state_ff;
   logic [PW-1:0]    end_ff, pos_ff, before_ff, len_ff, newlen_ff;
   logic             have_prev_ff, move_ff, reloc_ff, nxt_ok_ff;
   ffbta_pkg::op_type kind_ff;
   logic [AW-1:0]    blk_ff, n_ff, addr_ff, nb_ff, wr2_addr_ff;
   logic [7:0]       type_ff, tag_ff;
   ffbta_pkg::word_type wr2_data_ff;
   logic [1:0]       st_ff;
   logic [AW-1:0]    ra_ff, cf_ff, cb_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [AW-1:0]    rsp_ra_ff, rsp_cf_ff, rsp_cb_ff;

   logic [PW-1:0] n_hdr, d_len, rest, nxt_sum, total;
   logic [PW-1:0] clamp_in;

   assign n_hdr   = {1'b0, n_ff} + ffbta_pkg::HDR;
   assign d_len   = rd_data_ff.len;
   assign rest    = d_len - n_hdr;
   assign nxt_sum = {1'b0, blk_ff} + d_len;
   assign total   = d_len + len_ff;
   assign clamp_in = (csr_wr_data < ffbta_pkg::HDR) ? ffbta_pkg::HDR :
                     (csr_wr_data > ffbta_pkg::END_MAX) ? ffbta_pkg::END_MAX : csr_wr_data;

   assign req_ready       = (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_ra_ff;
   assign rsp_copy_from   = rsp_cf_ff;
   assign rsp_copy_bytes  = rsp_cb_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = pos_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = blk_ff;
      wr_data = '{len: n_hdr, tag: tag_ff};
      unique case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{len: end_ff, tag: ffbta_pkg::FREE_TAG};
         end
         S_AL_RD: rd_en = (pos_ff < end_ff);
         S_AL_EV: begin
            wr_addr = pos_ff[AW-1:0];
            wr_data = '{len: (rest >= ffbta_pkg::HDR) ? n_hdr : d_len, tag: type_ff};
            wr_en   = (d_len != '0) && (rd_data_ff.tag == ffbta_pkg::FREE_TAG) &&
                      (d_len >= n_hdr);
         end
         S_AL_WR2, S_RZ_WR2: begin
            wr_en   = 1'b1;
            wr_addr = wr2_addr_ff;
            wr_data = wr2_data_ff;
         end
         S_LC_RD: begin
            rd_en   = (pos_ff < end_ff);
            rd_addr = (pos_ff[AW-1:0] == blk_ff && !pos_ff[PW-1]) ? blk_ff : pos_ff[AW-1:0];
         end
         S_BK_EV: begin
            rd_en   = 1'b1;
            rd_addr = nxt_sum[AW-1:0];
            if (!(kind_ff == ffbta_pkg::OP_RESIZE && !reloc_ff) ||
                rd_data_ff.tag == ffbta_pkg::FREE_TAG) begin
               rd_en = !(kind_ff == ffbta_pkg::OP_RESIZE && !reloc_ff) ||
                       (rd_data_ff.tag != ffbta_pkg::FREE_TAG);
            end else if (n_hdr <= d_len) begin
               rd_en   = 1'b0;
               wr_en   = (d_len - {1'b0, n_ff}) >= ffbta_pkg::HDR2;
               wr_data = '{len: n_hdr, tag: rd_data_ff.tag};
            end
            if (!reloc_ff && kind_ff != ffbta_pkg::OP_RESIZE &&
                rd_data_ff.tag == ffbta_pkg::FREE_TAG) begin
               rd_en = 1'b0;
            end
         end
         S_NX_EV: begin
            wr_en   = 1'b1;
            wr_data = '{len: (nxt_ok_ff && rd_data_ff.tag == ffbta_pkg::FREE_TAG) ?
                              total : len_ff, tag: ffbta_pkg::FREE_TAG};
            rd_en   = have_prev_ff;
            rd_addr = before_ff[AW-1:0];
         end
         S_PV_EV: begin
            wr_addr = before_ff[AW-1:0];
            wr_data = '{len: d_len + newlen_ff, tag: ffbta_pkg::FREE_TAG};
            wr_en   = (rd_data_ff.tag == ffbta_pkg::FREE_TAG);
         end
         S_RZ_NX: begin
            if (nxt_ok_ff && rd_data_ff.tag == ffbta_pkg::FREE_TAG && total >= n_hdr) begin
               wr_en   = 1'b1;
               wr_data = '{len: ((total - {1'b0, n_ff}) >= ffbta_pkg::HDR2) ? n_hdr : total,
                           tag: tag_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         end_ff       <= ffbta_pkg::END_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            end_ff   <= clamp_in;
            state_ff <= S_INIT;
         end else begin
            unique case (state_ff)
               S_INIT: state_ff <= S_IDLE;
               S_IDLE: begin
                  if (req_valid) begin
                     kind_ff      <= ffbta_pkg::op_type'(req_op);
                     addr_ff      <= req_addr;
                     n_ff         <= req_size;
                     type_ff      <= req_block_type;
                     blk_ff       <= req_addr - AW'(ffbta_pkg::HEADER_BYTES);
                     pos_ff       <= '0;
                     have_prev_ff <= 1'b0;
                     move_ff      <= 1'b0;
                     reloc_ff     <= 1'b0;
                     st_ff        <= ffbta_pkg::ST_FAIL;
                     ra_ff        <= '0;
                     cf_ff        <= '0;
                     cb_ff        <= '0;
                     unique case (ffbta_pkg::op_type'(req_op))
                        ffbta_pkg::OP_ALLOC:
                           state_ff <= (req_block_type == ffbta_pkg::FREE_TAG) ?
                                       S_RESP : S_AL_RD;
                        ffbta_pkg::OP_FREE, ffbta_pkg::OP_RESIZE: begin
                           if (req_op == ffbta_pkg::OP_RESIZE && req_size == '0)
                              kind_ff <= ffbta_pkg::OP_FREE;
                           state_ff <= ({1'b0, req_addr} < ffbta_pkg::HDR) ? S_RESP : S_LC_RD;
                        end
                        default: state_ff <= S_RESP;
                     endcase
                  end
               end
               S_AL_RD: state_ff <= (pos_ff < end_ff) ? S_AL_EV : S_RESP;
               S_AL_EV: begin
                  if (d_len == '0) begin
                     state_ff <= S_RESP;
                  end else if (rd_data_ff.tag == ffbta_pkg::FREE_TAG && d_len >= n_hdr) begin
                     nb_ff       <= pos_ff[AW-1:0];
                     wr2_addr_ff <= pos_ff[AW-1:0] + n_hdr[AW-1:0];
                     wr2_data_ff <= '{len: rest, tag: ffbta_pkg::FREE_TAG};
                     if (rest >= ffbta_pkg::HDR) begin
                        state_ff <= S_AL_WR2;
                     end else if (!move_ff) begin
                        st_ff    <= ffbta_pkg::ST_DONE;
                        ra_ff    <= pos_ff[AW-1:0] + AW'(ffbta_pkg::HEADER_BYTES);
                        state_ff <= S_RESP;
                     end else begin
                        st_ff        <= ffbta_pkg::ST_MOVED;
                        ra_ff        <= pos_ff[AW-1:0] + AW'(ffbta_pkg::HEADER_BYTES);
                        cf_ff        <= addr_ff;
                        cb_ff        <= len_ff[AW-1:0] - AW'(ffbta_pkg::HEADER_BYTES);
                        reloc_ff     <= 1'b1;
                        pos_ff       <= '0;
                        have_prev_ff <= 1'b0;
                        state_ff     <= S_LC_RD;
                     end
                  end else begin
                     pos_ff   <= pos_ff + d_len;
                     state_ff <= S_AL_RD;
                  end
               end
               S_AL_WR2: begin
                  ra_ff <= nb_ff + AW'(ffbta_pkg::HEADER_BYTES);
                  if (!move_ff) begin
                     st_ff    <= ffbta_pkg::ST_DONE;
                     state_ff <= S_RESP;
                  end else begin
                     st_ff        <= ffbta_pkg::ST_MOVED;
                     cf_ff        <= addr_ff;
                     cb_ff        <= len_ff[AW-1:0] - AW'(ffbta_pkg::HEADER_BYTES);
                     reloc_ff     <= 1'b1;
                     pos_ff       <= '0;
                     have_prev_ff <= 1'b0;
                     state_ff     <= S_LC_RD;
                  end
               end
               S_LC_RD: begin
                  if (pos_ff >= end_ff) state_ff <= S_RESP;
                  else if (pos_ff == {1'b0, blk_ff}) state_ff <= S_BK_EV;
                  else state_ff <= S_LC_EV;
               end
               S_LC_EV: begin
                  if (d_len == '0) begin
                     state_ff <= S_RESP;
                  end else begin
                     before_ff    <= pos_ff;
                     have_prev_ff <= 1'b1;
                     pos_ff       <= pos_ff + d_len;
                     state_ff     <= S_LC_RD;
                  end
               end
               S_BK_EV: begin
                  len_ff    <= d_len;
                  tag_ff    <= rd_data_ff.tag;
                  nxt_ok_ff <= nxt_sum < end_ff;
                  if (!reloc_ff && rd_data_ff.tag == ffbta_pkg::FREE_TAG) begin
                     state_ff <= S_RESP;
                  end else if (reloc_ff || kind_ff == ffbta_pkg::OP_FREE) begin
                     if (!reloc_ff) st_ff <= ffbta_pkg::ST_DONE;
                     state_ff <= S_NX_EV;
                  end else if (n_hdr <= d_len) begin
                     st_ff       <= ffbta_pkg::ST_DONE;
                     ra_ff       <= addr_ff;
                     wr2_addr_ff <= blk_ff + n_hdr[AW-1:0];
                     wr2_data_ff <= '{len: d_len - n_hdr, tag: ffbta_pkg::FREE_TAG};
                     state_ff    <= ((d_len - {1'b0, n_ff}) >= ffbta_pkg::HDR2) ?
                                    S_RZ_WR2 : S_RESP;
                  end else begin
                     state_ff <= S_RZ_NX;
                  end
               end
               S_NX_EV: begin
                  newlen_ff <= (nxt_ok_ff && rd_data_ff.tag == ffbta_pkg::FREE_TAG) ?
                               total : len_ff;
                  state_ff  <= have_prev_ff ? S_PV_EV : S_RESP;
               end
               S_PV_EV: state_ff <= S_RESP;
               S_RZ_NX: begin
                  if (nxt_ok_ff && rd_data_ff.tag == ffbta_pkg::FREE_TAG &&
                      total >= n_hdr) begin
                     st_ff       <= ffbta_pkg::ST_DONE;
                     ra_ff       <= addr_ff;
                     wr2_addr_ff <= blk_ff + n_hdr[AW-1:0];
                     wr2_data_ff <= '{len: total - n_hdr, tag: ffbta_pkg::FREE_TAG};
                     state_ff    <= ((total - {1'b0, n_ff}) >= ffbta_pkg::HDR2) ?
                                    S_RZ_WR2 : S_RESP;
                  end else begin
                     move_ff  <= 1'b1;
                     type_ff  <= tag_ff;
                     pos_ff   <= '0;
                     state_ff <= S_AL_RD;
                  end
               end
               S_RZ_WR2: state_ff <= S_RESP;
               S_RESP: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= st_ff;
                     rsp_ra_ff     <= ra_ff;
                     rsp_cf_ff     <= cf_ff;
                     rsp_cb_ff     <= cb_ff;
                     state_ff      <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

endmodule
